// ===== sv/xml_entity_decoder_defines.svh =====
// Assertion macros for the entity decoder checker.
`ifndef XML_ENTITY_DECODER_DEFINES_SVH
`define XML_ENTITY_DECODER_DEFINES_SVH

// Checked outside reset only.
`define XED_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("xed assertion failed");

// Checked on every edge, reset included.
`define XED_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("xed assertion failed");

`endif

// ===== sv/xed_pkg.sv =====
package xed_pkg;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam int NUM_NAMES = 5;
    localparam logic [15:0] CODE_MAX  = 16'hFFFF;
    localparam logic [15:0] BYTE_MAX  = 16'h00FF;

    // amp, lt, gt, apos, quot; unused characters are zero
    localparam logic [NUM_NAMES-1:0][3:0][7:0] NAME_CHARS = '{
        '{8'h74, 8'h6F, 8'h75, 8'h71},
        '{8'h73, 8'h6F, 8'h70, 8'h61},
        '{8'h00, 8'h00, 8'h74, 8'h67},
        '{8'h00, 8'h00, 8'h74, 8'h6C},
        '{8'h00, 8'h70, 8'h6D, 8'h61}
    };
    localparam logic [NUM_NAMES-1:0][2:0] NAME_LEN = '{
        3'd4, 3'd4, 3'd2, 3'd2, 3'd3
    };
    localparam logic [NUM_NAMES-1:0][7:0] NAME_RESULT = '{
        8'h22, 8'h27, 8'h3E, 8'h3C, 8'h26
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       error;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [1:0] count;
        t_res       res1;
        t_res       res0;
    } t_push;

endpackage

// ===== sv/xed_if.sv =====
interface xed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface xed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       error;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output error,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input error,
                    input last, output ready);
endinterface

// ===== sv/xml_entity_decoder.sv =====
// A request is registered in the input register; its results are then written into the
// result queue once it has room. Throughput: one request per cycle while the queue has
// room; a numeric reference above 0xFF yields two results and holds the input while the
// output port drains. Set by the three-entry result queue and its single output port.
// Reset clears the parse state, the input register's valid flag and the result queue count.
module xml_entity_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xed_in_if.sink    i_in,
    xed_out_if.source o_out
);

    logic           room;
    logic           push_en;
    xed_pkg::t_push push;
    xed_pkg::t_res  res;

    xed_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_byte    (i_in.in_byte),
        .i_eos     (i_in.end_of_string),
        .i_room    (room),
        .o_push_en (push_en),
        .o_push    (push)
    );

    xed_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (push_en),
        .i_push    (push),
        .o_room    (room),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_res     (res)
    );

    assign o_out.out_byte   = res.out_byte;
    assign o_out.byte_valid = res.byte_valid;
    assign o_out.error      = res.error;
    assign o_out.last       = res.last;

endmodule

// ===== sv/xed_core.sv =====
module xed_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_eos,
    input  logic          i_room,
    output logic          o_push_en,
    output xed_pkg::t_push o_push
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NAME,
        MODE_HASH,
        MODE_HEX0,
        MODE_HEXN,
        MODE_DECN,
        MODE_DISCARD
    } t_mode;

    logic       r_in_v;
    logic [7:0] r_byte;
    logic       r_eos;

    t_mode       r_mode,  n_mode;
    logic [15:0] r_code,  n_code;
    logic        r_big,   n_big;
    logic [4:0]  r_cand,  n_cand;
    logic [2:0]  r_pos,   n_pos;

    logic        fire;
    logic        fail;
    logic        is_dig;
    logic        hex_ok;
    logic        dig_ok;
    logic [3:0]  dig_val;
    logic [3:0]  hex_val;
    logic [19:0] prod;
    logic [19:0] sum;
    logic        over;
    logic [4:0]  keep;
    logic        hit;
    logic [7:0]  hit_char;
    logic [1:0]  cnt;
    xed_pkg::t_res res [2];
    xed_pkg::t_res item;

    assign fire    = r_in_v && i_room;
    assign o_ready = !r_in_v || fire;

    always_comb begin
        is_dig  = (r_byte >= xed_pkg::CH_0) && (r_byte <= xed_pkg::CH_9);
        dig_val = 4'(r_byte - xed_pkg::CH_0);
        hex_ok  = 1'b1;
        if (is_dig) begin
            hex_val = dig_val;
        end else if (r_byte >= xed_pkg::CH_LA && r_byte <= xed_pkg::CH_LF) begin
            hex_val = 4'(r_byte - xed_pkg::CH_LA + 8'd10);
        end else if (r_byte >= xed_pkg::CH_UA && r_byte <= xed_pkg::CH_UF) begin
            hex_val = 4'(r_byte - xed_pkg::CH_UA + 8'd10);
        end else begin
            hex_val = 4'd0;
            hex_ok  = 1'b0;
        end
        if (r_mode == MODE_DECN) begin
            dig_ok = is_dig;
            prod   = {1'b0, r_code, 3'b000} + {3'b000, r_code, 1'b0};
            sum    = prod + {16'd0, dig_val};
        end else begin
            dig_ok = hex_ok;
            prod   = {r_code, 4'b0000};
            sum    = prod + {16'd0, hex_val};
        end
        over = (sum[19:16] != 4'd0);
    end

    always_comb begin
        keep     = '0;
        hit      = 1'b0;
        hit_char = '0;
        for (int i = 0; i < xed_pkg::NUM_NAMES; i++) begin
            if (r_cand[i]) begin
                if (r_pos < xed_pkg::NAME_LEN[i]) begin
                    if (xed_pkg::NAME_CHARS[i][r_pos[1:0]] == r_byte) begin
                        keep[i] = 1'b1;
                    end
                end else if (r_pos == xed_pkg::NAME_LEN[i] && r_byte == xed_pkg::CH_SEMI) begin
                    hit      = 1'b1;
                    hit_char = xed_pkg::NAME_RESULT[i];
                end
            end
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_code = r_code;
        n_big  = r_big;
        n_cand = r_cand;
        n_pos  = r_pos;
        fail   = 1'b0;
        cnt    = 2'd0;
        res[0] = '0;
        res[1] = '0;
        item   = '0;

        case (r_mode)
            MODE_IDLE: begin
                if (r_byte == xed_pkg::CH_AMP) begin
                    n_mode = MODE_NAME;
                    n_cand = '1;
                    n_pos  = '0;
                end else begin
                    item.out_byte   = r_byte;
                    item.byte_valid = 1'b1;
                    res[cnt[0]]     = item;
                    cnt             = cnt + 2'd1;
                end
            end
            MODE_NAME: begin
                if (r_pos == 3'd0 && r_byte == xed_pkg::CH_HASH) begin
                    n_mode = MODE_HASH;
                end else if (hit) begin
                    item.out_byte   = hit_char;
                    item.byte_valid = 1'b1;
                    res[cnt[0]]     = item;
                    cnt             = cnt + 2'd1;
                    n_mode          = MODE_IDLE;
                end else if (keep == '0) begin
                    fail = 1'b1;
                end else begin
                    n_cand = keep;
                    n_pos  = r_pos + 3'd1;
                end
            end
            MODE_HASH: begin
                n_code = '0;
                n_big  = 1'b0;
                if (r_byte == xed_pkg::CH_X) begin
                    n_mode = MODE_HEX0;
                end else if (is_dig) begin
                    n_code = {12'd0, dig_val};
                    n_mode = MODE_DECN;
                end else begin
                    fail = 1'b1;
                end
            end
            MODE_HEX0, MODE_HEXN, MODE_DECN: begin
                if (dig_ok) begin
                    n_code = over ? xed_pkg::CODE_MAX : sum[15:0];
                    n_big  = r_big || over;
                    if (r_mode == MODE_HEX0) begin
                        n_mode = MODE_HEXN;
                    end
                end else if (r_byte == xed_pkg::CH_SEMI && r_mode != MODE_HEX0) begin
                    if (r_big) begin
                        fail = 1'b1;
                    end else begin
                        item.byte_valid = 1'b1;
                        if (r_code > xed_pkg::BYTE_MAX) begin
                            item.out_byte = r_code[15:8];
                            res[cnt[0]]   = item;
                            cnt           = cnt + 2'd1;
                        end
                        item.out_byte = r_code[7:0];
                        res[cnt[0]]   = item;
                        cnt           = cnt + 2'd1;
                        n_mode        = MODE_IDLE;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (fail) begin
            item        = '0;
            item.error  = 1'b1;
            res[cnt[0]] = item;
            cnt         = cnt + 2'd1;
            n_mode      = MODE_DISCARD;
        end

        if (r_eos) begin
            if (n_mode != MODE_IDLE && n_mode != MODE_DISCARD) begin
                item        = '0;
                item.error  = 1'b1;
                res[cnt[0]] = item;
                cnt         = cnt + 2'd1;
            end else if (cnt == 2'd0) begin
                item        = '0;
                res[0]      = item;
                cnt         = 2'd1;
            end
            if (cnt == 2'd2) begin
                res[1].last = 1'b1;
            end else begin
                res[0].last = 1'b1;
            end
            n_mode = MODE_IDLE;
            n_code = '0;
            n_big  = 1'b0;
            n_cand = '1;
            n_pos  = '0;
        end
    end

    assign o_push_en    = fire;
    assign o_push.count = cnt;
    assign o_push.res0  = res[0];
    assign o_push.res1  = res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_mode <= MODE_IDLE;
            r_code <= '0;
            r_big  <= 1'b0;
            r_cand <= '1;
            r_pos  <= '0;
        end else begin
            if (o_ready) begin
                r_in_v <= i_valid;
            end
            if (fire) begin
                r_mode <= n_mode;
                r_code <= n_code;
                r_big  <= n_big;
                r_cand <= n_cand;
                r_pos  <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_eos  <= i_eos;
        end
    end

endmodule

// ===== sv/xed_outq.sv =====
module xed_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_en,
    input  xed_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output xed_pkg::t_res  o_res
);

    xed_pkg::t_res r_q [3];
    xed_pkg::t_res n_q [3];
    logic [1:0]    r_cnt, n_cnt;
    logic          pop;
    logic [1:0]    base;
    logic [1:0]    add;

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_q[0];
    assign o_room  = (r_cnt <= 2'd1);
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_q  = r_q;
        base = r_cnt - {1'b0, pop};
        add  = i_push_en ? i_push.count : 2'd0;
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
        end
        if (add != 2'd0) begin
            n_q[base] = i_push.res0;
        end
        if (add == 2'd2) begin
            n_q[base + 2'd1] = i_push.res1;
        end
        n_cnt = base + add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

// ===== sv/xed_checker.sv =====
`include "xml_entity_decoder_defines.svh"

module xed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_error
);

    `XED_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `XED_ASSERT(a_err_no_byte, i_clk, i_rst_n, i_out_valid |-> !(i_byte_valid && i_error))
    `XED_ASSERT(a_empty_zero, i_clk, i_rst_n, i_out_valid && !i_byte_valid |-> i_out_byte == 8'h00)
    `XED_ASSERT_ALL(a_rst_idle, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind xml_entity_decoder xed_checker u_xed_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_byte_valid (o_out.byte_valid),
    .i_error      (o_out.error)
);

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] t_byte_q[$];
    typedef enum logic [2:0] {
        PM_IDLE, PM_NAME, PM_HASH, PM_HEX0, PM_HEXN, PM_DECN, PM_DISCARD
    } t_parse_mode;

    localparam logic [7:0] CH_UX = 8'h58;

    logic i_clk;
    logic i_rst_n;

    xed_in_if  req_if();
    xed_out_if res_if();

    xml_entity_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // decoder state as predicted
    t_parse_mode pm       = PM_IDLE;
    logic [15:0] code_val = '0;
    logic        too_big  = 1'b0;
    logic [4:0]  cand     = '1;
    int          npos     = 0;

    string      ent_name [5] = '{"amp", "lt", "gt", "apos", "quot"};
    logic [7:0] ent_char [5] = '{8'h26, 8'h3C, 8'h3E, 8'h27, 8'h22};

    xed_pkg::t_res decoded_q[$];

    int n_mismatch = 0;
    int n_sent     = 0;
    int n_strings  = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_names    = 0;
    int n_wide     = 0;

    logic src_calm  = 1'b0;
    logic sink_calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("timeout with %0d results outstanding", decoded_q.size());
        $display("xml_entity_decoder: mismatch");
        $finish;
    end

    function automatic xed_pkg::t_res mk_res(logic [7:0] b, logic v, logic e);
        return xed_pkg::t_res'{out_byte: b, byte_valid: v, error: e, last: 1'b0};
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    function automatic void predict_decode(logic [7:0] b, logic eos);
        xed_pkg::t_res step_res[$];
        logic          fail;
        logic [4:0]    keep;
        int            hit;
        int            d;
        int            base;
        int            v;
        fail = 1'b0;
        case (pm)
            PM_IDLE: begin
                if (b == xed_pkg::CH_AMP) begin
                    pm   = PM_NAME;
                    cand = '1;
                    npos = 0;
                end else begin
                    step_res.push_back(mk_res(b, 1'b1, 1'b0));
                end
            end
            PM_NAME: begin
                if (npos == 0 && b == xed_pkg::CH_HASH) begin
                    pm = PM_HASH;
                end else begin
                    keep = '0;
                    hit  = -1;
                    for (int i = 0; i < 5; i++) begin
                        if (cand[i]) begin
                            if (npos < ent_name[i].len()) begin
                                if (8'(ent_name[i][npos]) == b) keep[i] = 1'b1;
                            end else if (npos == ent_name[i].len() &&
                                         b == xed_pkg::CH_SEMI) begin
                                hit = i;
                            end
                        end
                    end
                    if (hit >= 0) begin
                        step_res.push_back(mk_res(ent_char[hit], 1'b1, 1'b0));
                        pm = PM_IDLE;
                        n_names++;
                    end else if (keep == '0) begin
                        fail = 1'b1;
                    end else begin
                        cand = keep;
                        npos = npos + 1;
                    end
                end
            end
            PM_HASH: begin
                code_val = '0;
                too_big  = 1'b0;
                if (b == xed_pkg::CH_X) begin
                    pm = PM_HEX0;
                end else if (b >= xed_pkg::CH_0 && b <= xed_pkg::CH_9) begin
                    code_val = 16'(b - xed_pkg::CH_0);
                    pm       = PM_DECN;
                end else begin
                    fail = 1'b1;
                end
            end
            PM_HEX0, PM_HEXN, PM_DECN: begin
                d = -1;
                if (b >= xed_pkg::CH_0 && b <= xed_pkg::CH_9)
                    d = int'(b) - int'(xed_pkg::CH_0);
                else if (pm != PM_DECN && b >= xed_pkg::CH_LA && b <= xed_pkg::CH_LF)
                    d = int'(b) - int'(xed_pkg::CH_LA) + 10;
                else if (pm != PM_DECN && b >= xed_pkg::CH_UA && b <= xed_pkg::CH_UF)
                    d = int'(b) - int'(xed_pkg::CH_UA) + 10;
                base = (pm == PM_DECN) ? 10 : 16;
                if (d >= 0) begin
                    v = int'(code_val) * base + d;
                    if (v > int'(xed_pkg::CODE_MAX)) begin
                        too_big = 1'b1;
                        v       = int'(xed_pkg::CODE_MAX);
                    end
                    code_val = 16'(v);
                    if (pm == PM_HEX0) pm = PM_HEXN;
                end else if (b == xed_pkg::CH_SEMI && pm != PM_HEX0) begin
                    if (too_big) begin
                        fail = 1'b1;
                    end else begin
                        if (code_val > xed_pkg::BYTE_MAX) begin
                            step_res.push_back(mk_res(code_val[15:8], 1'b1, 1'b0));
                            n_wide++;
                        end
                        step_res.push_back(mk_res(code_val[7:0], 1'b1, 1'b0));
                        pm = PM_IDLE;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            default: ;
        endcase
        if (fail) begin
            step_res.push_back(mk_res(8'h00, 1'b0, 1'b1));
            pm = PM_DISCARD;
        end
        if (eos) begin
            if (pm != PM_IDLE && pm != PM_DISCARD) step_res.push_back(mk_res(8'h00, 1'b0, 1'b1));
            else if (step_res.size() == 0) step_res.push_back(mk_res(8'h00, 1'b0, 1'b0));
            step_res[step_res.size()-1].last = 1'b1;
            pm       = PM_IDLE;
            code_val = '0;
            too_big  = 1'b0;
            cand     = '1;
            npos     = 0;
        end
        foreach (step_res[k]) begin
            decoded_q.push_back(step_res[k]);
            n_results++;
            if (step_res[k].error) n_errors++;
        end
    endfunction

    task automatic report_mismatch(string what, logic [7:0] exp_v, logic [7:0] got_v);
        n_mismatch++;
        $display("%0t ns: %s: expected %h, got %h", $time, what, exp_v, got_v);
    endtask

    // called and returns at a falling edge; valid stays high across back-to-back requests
    task automatic send_byte(logic [7:0] b, logic eos);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            req_if.valid   = 1'b0;
            req_if.in_byte = 8'($urandom_range(0, 255));
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid         = 1'b1;
        req_if.in_byte       = b;
        req_if.end_of_string = eos;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_decode(b, eos);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(t_byte_q s);
        foreach (s[k]) send_byte(s[k], k == s.size() - 1);
        n_strings++;
    endtask

    function automatic void push_text(ref t_byte_q q, input string t);
        for (int k = 0; k < t.len(); k++) q.push_back(8'(t[k]));
    endfunction

    // one random piece of text: plain bytes, a reference, or a broken reference
    function automatic void add_segment(ref t_byte_q s);
        int   r;
        int   n;
        int   i;
        int   d;
        logic hex;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            n = $urandom_range(1, 4);
            repeat (n) s.push_back(8'($urandom_range(0, 255)));
        end else if (r < 60) begin
            i = $urandom_range(0, 4);
            push_text(s, {"&", ent_name[i], ";"});
        end else if (r < 80) begin
            hex = (r < 70);
            if (hex) push_text(s, "&#x");
            else push_text(s, "&#");
            n = $urandom_range(1, hex ? 5 : 6);
            repeat (n) begin
                d = $urandom_range(0, hex ? 15 : 9);
                if (d < 10) s.push_back(xed_pkg::CH_0 + 8'(d));
                else s.push_back(($urandom_range(0, 1) ? xed_pkg::CH_UA : xed_pkg::CH_LA)
                                 + 8'(d - 10));
            end
            s.push_back(xed_pkg::CH_SEMI);
        end else if (r < 90) begin
            i = $urandom_range(0, 4);
            n = $urandom_range(0, ent_name[i].len());
            s.push_back(xed_pkg::CH_AMP);
            for (int k = 0; k < n; k++) s.push_back(8'(ent_name[i][k]));
            s.push_back(8'($urandom_range(0, 255)));
        end else begin
            push_text(s, "&#");
            case ($urandom_range(0, 3))
                1: begin
                    s.push_back(xed_pkg::CH_X);
                    repeat ($urandom_range(0, 3))
                        s.push_back(xed_pkg::CH_0 + 8'($urandom_range(0, 9)));
                end
                2: repeat ($urandom_range(1, 3))
                    s.push_back(xed_pkg::CH_0 + 8'($urandom_range(0, 9)));
                3: s.push_back(CH_UX);
                default: ;
            endcase
            s.push_back($urandom_range(0, 1) ? xed_pkg::CH_SEMI : 8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic test_plain_and_names();
        t_byte_q s;
        s = {};
        s.push_back(8'h00);
        push_text(s, "&quot;");
        s.push_back(8'hFF);
        send_text(s);
    endtask

    task automatic test_numeric_refs();
        t_byte_q s;
        s = {};
        push_text(s, "&#x1aF;");
        send_text(s);
        s = {};
        push_text(s, "&#70000;");
        send_text(s);
    endtask

    task automatic test_error_paths();
        t_byte_q s;
        s = {};
        push_text(s, "&gxa");
        send_text(s);
        s = {};
        push_text(s, "&#");
        send_text(s);
    endtask

    task automatic test_random_text();
        t_byte_q s;
        int      nseg;
        int      cut;
        while (n_sent < 1700) begin
            s        = {};
            src_calm = ($urandom_range(0, 4) == 0);
            nseg     = $urandom_range(1, 8);
            repeat (nseg) add_segment(s);
            // sometimes cut the string short, possibly part way through a reference
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, s.size());
                while (s.size() > cut) void'(s.pop_back());
            end
            send_text(s);
        end
        src_calm = 1'b0;
    endtask

    initial begin
        int cyc;
        int stall;
        cyc          = 0;
        stall        = 0;
        res_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 200 == 0) sink_calm = ($urandom_range(0, 3) == 0);
            if (stall > 0) begin
                res_if.ready = 1'b0;
                stall--;
            end else begin
                stall = pick_gap(sink_calm);
                if (stall == 0) begin
                    res_if.ready = 1'b1;
                end else begin
                    res_if.ready = 1'b0;
                    stall--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        xed_pkg::t_res got;
        xed_pkg::t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = xed_pkg::t_res'{out_byte: res_if.out_byte, byte_valid: res_if.byte_valid,
                                  error: res_if.error, last: res_if.last};
            if (decoded_q.size() == 0) begin
                report_mismatch("result with none outstanding", 8'h00, got.out_byte);
            end else begin
                want = decoded_q.pop_front();
                if (got.out_byte !== want.out_byte)
                    report_mismatch("out_byte", want.out_byte, got.out_byte);
                if (got.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
                if (got.error !== want.error)
                    report_mismatch("error", 8'(want.error), 8'(got.error));
                if (got.last !== want.last)
                    report_mismatch("last", 8'(want.last), 8'(got.last));
            end
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.in_byte       = 8'h00;
        req_if.end_of_string = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_plain_and_names();
        test_numeric_refs();
        test_error_paths();
        test_random_text();

        req_if.valid = 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d bytes in %0d strings decoded into %0d results, %0d of them errors",
                 n_sent, n_strings, n_results, n_errors);
        $display("%0d named entities, %0d two-byte numeric references, %0d mismatches",
                 n_names, n_wide, n_mismatch);
        if (n_mismatch == 0) begin
            $display("xml_entity_decoder: match");
        end else begin
            $display("xml_entity_decoder: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/xed_pkg.sv
sv/xed_if.sv
sv/xed_core.sv
sv/xed_outq.sv
sv/xml_entity_decoder.sv
sv/xed_checker.sv
test/testbench.sv
